### src/swml_pkg.sv
package swml_pkg;

  localparam int unsigned InWidth  = 3 + 32 + 1 + 32 + 16 + 64 + 16 + 16 + 64 + 1 + 1;
  localparam int unsigned InBytes  = (InWidth + 7) / 8;
  localparam int unsigned OutWidth = 4 + 32 + 16 + 16 + 64;
  localparam int unsigned OutBytes = (OutWidth + 7) / 8;

  localparam logic [15:0] CmdInit    = 16'hFFFF;
  localparam logic [15:0] CmdInitAck = 16'hFFFE;
  localparam logic [15:0] CmdMsgAck  = 16'hFFFD;
  localparam logic [15:0] CmdPing    = 16'hFFFC;
  localparam logic [15:0] StaleWindow = 16'd30000;
  localparam logic [15:0] HeaderBytes = 16'd20;
  localparam logic [31:0] Broadcast   = 32'hFFFF_FFFF;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    ModeTick  = 3'd0,
    ModeRx    = 3'd1,
    ModeSend  = 3'd2,
    ModeResp  = 3'd3,
    ModeStart = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    KindSend      = 4'd0,
    KindReply     = 4'd1,
    KindLinkUp    = 4'd2,
    KindLinkDown  = 4'd3,
    KindServerUp  = 4'd4,
    KindServerDn  = 4'd5,
    KindDelivered = 4'd6,
    KindCancelled = 4'd7,
    KindCommand   = 4'd8,
    KindRefused   = 4'd9,
    KindAccepted  = 4'd10
  } kind_e;

  typedef enum logic [2:0] {
    RegDeviceId   = 3'd0,
    RegServerId   = 3'd1,
    RegVersion    = 3'd2,
    RegConnResend = 3'd3,
    RegDiscResend = 3'd4,
    RegIdlePing   = 3'd5,
    RegMaxTries   = 3'd6
  } reg_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] now_ms;
    logic        link_up;
    logic [31:0] src_address;
    logic        hdr_ok;   // length and identity checked in the front end
    logic [15:0] msg_id;
    logic [15:0] command;
    logic [63:0] args;
    logic        blocking;
    logic        force_send;
  } item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] dest_address;
    logic [15:0] msg_id_res;
    logic [15:0] command_res;
    logic [63:0] args_res;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [63:0] device_id;
    logic [15:0] server_id;
    logic [15:0] device_version;
    logic [15:0] connected_resend_ms;
    logic [19:0] disconnected_resend_ms;
    logic [19:0] idle_ping_ms;
    logic [7:0]  max_tries;
  } cfg_t;

endpackage

### src/swml_front.sv
module swml_front
  import swml_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [8*InBytes-1:0]  s_axis_tdata,
  input  logic [63:0]           device_id_i,
  output logic                  item_valid_o,
  input  logic                  item_ready_i,
  output item_t                 item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  item_t            cls;
  logic             push, pop;

  // Classify: unpack fields and check the header once here
  always_comb begin
    cls.mode        = s_axis_tdata[2:0];
    cls.now_ms      = s_axis_tdata[34:3];
    cls.link_up     = s_axis_tdata[35];
    cls.src_address = s_axis_tdata[67:36];
    cls.hdr_ok      = (s_axis_tdata[83:68] >= HeaderBytes) &&
                      (s_axis_tdata[147:84] == device_id_i);
    cls.msg_id      = s_axis_tdata[163:148];
    cls.command     = s_axis_tdata[179:164];
    cls.args        = s_axis_tdata[243:180];
    cls.blocking    = s_axis_tdata[244];
    cls.force_send  = s_axis_tdata[245];
  end

  assign s_axis_tready = (cnt_q != (PtrW+1)'(Depth));
  assign push = s_axis_tvalid && s_axis_tready;
  assign item_valid_o = (cnt_q != '0);
  assign pop = item_valid_o && item_ready_i;
  assign item_o = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push) wr_d = (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
    if (pop)  rd_d = (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cls;
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth)) else $error("queue count overflow");
  a_full_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (PtrW+1)'(Depth)) |-> !push) else $error("push into full queue");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("count slip");
`endif

endmodule

### src/swml_back.sv
module swml_back
  import swml_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  input  item_t                 item_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [8*OutBytes-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  // architectural state
  logic        link_seen_q, link_seen_d, server_up_q, server_up_d;
  logic        sending_q, sending_d, held_blk_q, held_blk_d;
  logic [7:0]  tries_q, tries_d;
  logic [31:0] last_rx_time_q, last_rx_time_d, last_tx_time_q, last_tx_time_d;
  logic [15:0] cur_id_q, cur_id_d, last_rx_id_q, last_rx_id_d;
  logic [15:0] last_ans_q, last_ans_d, held_cmd_q, held_cmd_d;
  logic [31:0] srv_addr_q, srv_addr_d;
  logic [63:0] held_args_q, held_args_d;

  // up to three results per item, drained one per cycle unless the output stalls
  result_t     res_q [3];
  result_t     res_d [3];
  logic [1:0]  nres_q, nres_d, pos_q, pos_d;
  logic [1:0]  n;
  logic        busy;
  logic        take;
  logic        out_v_q;
  result_t     out_q;

  logic [31:0] elapsed, idle;
  logic [19:0] interval;
  logic [15:0] next_id, nid;
  logic [15:0] rx_gap;
  logic [63:0] init_args;

  assign busy         = (pos_q != nres_q);
  assign item_ready_o = !busy;
  assign take         = item_valid_i && !busy;

  assign elapsed   = item_i.now_ms - last_tx_time_q;
  assign idle      = item_i.now_ms - last_rx_time_q;
  assign interval  = server_up_q ? {4'd0, cfg_i.connected_resend_ms}
                                 : cfg_i.disconnected_resend_ms;
  assign next_id   = (cur_id_q == 16'hFFFF) ? 16'd1 : cur_id_q + 16'd1;
  assign rx_gap    = last_rx_id_q - item_i.msg_id;
  assign init_args = {32'd0, cfg_i.server_id, cfg_i.device_version};

  function automatic result_t mk(kind_e k, logic [31:0] d, logic [15:0] id,
                                 logic [15:0] c, logic [63:0] a);
    result_t r;
    r.kind = k; r.dest_address = d; r.msg_id_res = id;
    r.command_res = c; r.args_res = a; r.last = 1'b0;
    return r;
  endfunction

  always_comb begin
    link_seen_d = link_seen_q; server_up_d = server_up_q;
    sending_d = sending_q; held_blk_d = held_blk_q; tries_d = tries_q;
    last_rx_time_d = last_rx_time_q; last_tx_time_d = last_tx_time_q;
    cur_id_d = cur_id_q; last_rx_id_d = last_rx_id_q; last_ans_d = last_ans_q;
    srv_addr_d = srv_addr_q; held_cmd_d = held_cmd_q; held_args_d = held_args_q;
    res_d = res_q;
    n = '0;
    nid = next_id;
    if (take) begin
      case (item_i.mode)
        ModeTick: begin
          if (item_i.link_up) begin
            if (!link_seen_q) begin
              link_seen_d = 1'b1;
              res_d[n] = mk(KindLinkUp, '0, '0, '0, '0); n = n + 2'd1;
            end
            if (sending_q) begin
              if (elapsed > {12'd0, interval}) begin
                if (server_up_q && tries_q >= cfg_i.max_tries) begin
                  server_up_d = 1'b0;
                  srv_addr_d  = Broadcast;
                  res_d[n] = mk(KindServerDn, '0, '0, '0, '0); n = n + 2'd1;
                end else begin
                  if (tries_q != 8'hFF) tries_d = tries_q + 8'd1;
                  last_tx_time_d = item_i.now_ms;
                  res_d[n] = mk(KindSend, srv_addr_q, cur_id_q, held_cmd_q, held_args_q);
                  n = n + 2'd1;
                end
              end
            end else if (idle >= {12'd0, cfg_i.idle_ping_ms}) begin
              cur_id_d = next_id; held_cmd_d = CmdPing; held_args_d = '0;
              sending_d = 1'b1; held_blk_d = 1'b0; tries_d = 8'd1;
              last_tx_time_d = item_i.now_ms;
              res_d[n] = mk(KindSend, srv_addr_q, next_id, CmdPing, '0); n = n + 2'd1;
            end
          end else if (link_seen_q) begin
            link_seen_d = 1'b0;
            if (server_up_q) begin
              server_up_d = 1'b0;
              res_d[n] = mk(KindServerDn, '0, '0, '0, '0); n = n + 2'd1;
            end
            res_d[n] = mk(KindLinkDown, '0, '0, '0, '0); n = n + 2'd1;
          end
        end
        ModeRx: begin
          if (!link_seen_q) begin
            link_seen_d = 1'b1;
            res_d[n] = mk(KindLinkUp, '0, '0, '0, '0); n = n + 2'd1;
          end
          if (item_i.hdr_ok) begin
            if (!server_up_q) begin
              tries_d = '0; server_up_d = 1'b1; srv_addr_d = item_i.src_address;
              res_d[n] = mk(KindServerUp, '0, '0, '0, '0); n = n + 2'd1;
            end
            last_rx_time_d = item_i.now_ms;
            if (item_i.command == CmdInit || item_i.command == CmdInitAck) begin
              last_rx_id_d = '0; tries_d = '0;
              if (item_i.command == CmdInit) begin
                res_d[n] = mk(KindReply, srv_addr_d, item_i.msg_id, CmdInitAck, init_args);
                n = n + 2'd1;
              end else begin
                sending_d = 1'b0;
              end
            end else if (item_i.command == CmdPing) begin
              res_d[n] = mk(KindReply, srv_addr_d, item_i.msg_id, CmdMsgAck, '0);
              n = n + 2'd1;
            end else if (item_i.command == CmdMsgAck) begin
              if (sending_q && item_i.msg_id == cur_id_q) begin
                sending_d = 1'b0; tries_d = '0;
                if (held_cmd_q != CmdPing) begin
                  res_d[n] = mk(KindDelivered, '0, cur_id_q, held_cmd_q,
                                {48'd0, item_i.args[15:0]});
                  n = n + 2'd1;
                end
              end
            end else if (item_i.msg_id > last_rx_id_q || rx_gap > StaleWindow) begin
              last_rx_id_d = item_i.msg_id;
              res_d[n] = mk(KindCommand, '0, item_i.msg_id, item_i.command, item_i.args);
              n = n + 2'd1;
            end else if (item_i.msg_id == last_rx_id_q) begin
              res_d[n] = mk(KindReply, srv_addr_d, item_i.msg_id, CmdMsgAck,
                            {48'd0, last_ans_q});
              n = n + 2'd1;
            end
          end
        end
        ModeSend: begin
          if (sending_q && held_blk_q && !item_i.force_send) begin
            res_d[n] = mk(KindRefused, '0, '0, '0, '0); n = n + 2'd1;
          end else begin
            if (sending_q && held_cmd_q != CmdPing) begin
              res_d[n] = mk(KindCancelled, '0, cur_id_q, held_cmd_q, '0); n = n + 2'd1;
            end
            cur_id_d = next_id; held_cmd_d = item_i.command; held_args_d = item_i.args;
            sending_d = 1'b1; held_blk_d = item_i.blocking; tries_d = 8'd1;
            last_tx_time_d = item_i.now_ms;
            res_d[n] = mk(KindSend, srv_addr_q, next_id, item_i.command, item_i.args);
            n = n + 2'd1;
            res_d[n] = mk(KindAccepted, '0, next_id, '0, '0); n = n + 2'd1;
          end
        end
        ModeResp: begin
          last_ans_d = item_i.args[15:0];
          res_d[n] = mk(KindReply, srv_addr_q, last_rx_id_q, CmdMsgAck,
                        {48'd0, item_i.args[15:0]});
          n = n + 2'd1;
        end
        ModeStart: begin
          nid = 16'd1;
          srv_addr_d = Broadcast; server_up_d = 1'b0; link_seen_d = 1'b0;
          last_rx_time_d = '0;
          cur_id_d = nid; held_cmd_d = CmdInit; held_args_d = init_args;
          sending_d = 1'b1; held_blk_d = 1'b1; tries_d = 8'd1;
          last_tx_time_d = item_i.now_ms;
          res_d[n] = mk(KindSend, Broadcast, nid, CmdInit, init_args); n = n + 2'd1;
        end
        default: ;
      endcase
      if (n != '0) res_d[n-2'd1].last = 1'b1;
    end
  end

  // drain queue into a registered output stage
  logic load;
  assign load = busy && (!out_v_q || m_axis_tready);

  always_comb begin
    nres_d = nres_q;
    pos_d  = pos_q;
    if (take) begin
      nres_d = n;
      pos_d  = '0;
    end else if (load) begin
      pos_d = pos_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_seen_q <= 1'b0; server_up_q <= 1'b0; sending_q <= 1'b0;
      held_blk_q <= 1'b0; tries_q <= '0; last_rx_time_q <= '0;
      last_tx_time_q <= '0; cur_id_q <= '0; last_rx_id_q <= '0;
      last_ans_q <= '0; srv_addr_q <= Broadcast; held_cmd_q <= '0;
      held_args_q <= '0; nres_q <= '0; pos_q <= '0; out_v_q <= 1'b0;
    end else begin
      link_seen_q <= link_seen_d; server_up_q <= server_up_d; sending_q <= sending_d;
      held_blk_q <= held_blk_d; tries_q <= tries_d; last_rx_time_q <= last_rx_time_d;
      last_tx_time_q <= last_tx_time_d; cur_id_q <= cur_id_d;
      last_rx_id_q <= last_rx_id_d; last_ans_q <= last_ans_d;
      srv_addr_q <= srv_addr_d; held_cmd_q <= held_cmd_d; held_args_q <= held_args_d;
      nres_q <= nres_d; pos_q <= pos_d;
      if (load) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (load) out_q <= res_q[pos_q];
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {{(8*OutBytes-OutWidth){1'b0}}, out_q.args_res, out_q.command_res,
                          out_q.msg_id_res, out_q.dest_address, out_q.kind};

`ifndef ASSERT_OFF
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= nres_q) else $error("drain position past result count");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !take) else $error("item taken while draining");
  a_sending_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sending_q |-> (cur_id_q != '0)) else $error("outstanding message with id zero");
`endif

endmodule

### src/stop_and_wait_message_link.sv
// Stop-and-wait message link, device side.
// s_axis: one beat per event. tdata (low bit up): mode[2:0], now_ms[31:0],
//   link_up, src_address[31:0], pkt_length[15:0], pkt_device_id[63:0],
//   msg_id[15:0], command[15:0], args[63:0], blocking, force_send.
// m_axis: one beat per result; tlast marks the last result of an event.
//   tdata: kind[3:0], dest_address, msg_id_res, command_res, args_res.
// APB: seven registers at 8*i (64-bit data), written any time the link
//   is idle; pready is tied high.
// Events pass through a two-entry classify queue; the back end takes one
// event per cycle when it has no results left to drain, then emits its
// 0..3 results one per cycle while m_axis is not stalled, through a
// registered output stage. No new event is taken until every result of
// the last has been loaded into that stage; tvalid of the first result
// rises once the results are registered and then loaded into that stage.
// Reset: state cleared, server address broadcast, registers at defaults.
// A stalled m_axis holds its beat; the queue then fills and s_axis_tready
// falls.
module stop_and_wait_message_link
  import swml_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [8*InBytes-1:0]  s_axis_tdata,   // fields listed above
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [8*OutBytes-1:0] m_axis_tdata,   // kind, dest, id, command, args
  output logic                  m_axis_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [5:0]            paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  cfg_t  cfg_q;
  item_t item;
  logic  item_valid, item_ready;
  logic  wr;
  reg_e  ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = reg_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_id <= '0;
      cfg_q.server_id <= '0;
      cfg_q.device_version <= '0;
      cfg_q.connected_resend_ms <= 16'd1000;
      cfg_q.disconnected_resend_ms <= 20'd10000;
      cfg_q.idle_ping_ms <= 20'd5000;
      cfg_q.max_tries <= 8'd5;
    end else if (wr && paddr[2:0] == 3'd0) begin
      case (ridx)
        RegDeviceId:   cfg_q.device_id <= pwdata;
        RegServerId:   cfg_q.server_id <= pwdata[15:0];
        RegVersion:    cfg_q.device_version <= pwdata[15:0];
        RegConnResend: cfg_q.connected_resend_ms <= pwdata[15:0];
        RegDiscResend: cfg_q.disconnected_resend_ms <= pwdata[19:0];
        RegIdlePing:   cfg_q.idle_ping_ms <= pwdata[19:0];
        RegMaxTries:   cfg_q.max_tries <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      RegDeviceId:   prdata = cfg_q.device_id;
      RegServerId:   prdata = {48'd0, cfg_q.server_id};
      RegVersion:    prdata = {48'd0, cfg_q.device_version};
      RegConnResend: prdata = {48'd0, cfg_q.connected_resend_ms};
      RegDiscResend: prdata = {44'd0, cfg_q.disconnected_resend_ms};
      RegIdlePing:   prdata = {44'd0, cfg_q.idle_ping_ms};
      RegMaxTries:   prdata = {56'd0, cfg_q.max_tries};
      default:       prdata = '0;
    endcase
  end

  swml_front #(.Depth(Depth)) u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .device_id_i(cfg_q.device_id),
    .item_valid_o(item_valid), .item_ready_i(item_ready), .item_o(item)
  );

  swml_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .item_valid_i(item_valid), .item_ready_o(item_ready), .item_i(item),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import swml_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] now_ms;
    logic        link_up;
    logic [31:0] src_address;
    logic [15:0] pkt_length;
    logic [63:0] pkt_device_id;
    logic [15:0] msg_id;
    logic [15:0] command;
    logic [63:0] args;
    logic        blocking;
    logic        force_send;
  } event_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // mode, now_ms, link_up, src_address, pkt_length, pkt_device_id, msg_id,
  // command, args, blocking, force_send
  logic [8*InBytes-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // kind, dest_address, msg_id_res, command_res, args_res
  logic [8*OutBytes-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [5:0]            paddr = '0;
  logic [63:0]           pwdata = '0;
  logic [63:0]           prdata;
  logic                  pready;

  stop_and_wait_message_link dut (.*);

  always #5 clk_i = ~clk_i;

  // register mirror
  logic [63:0] dev_id;
  logic [15:0] srv_id, dev_ver, conn_resend;
  logic [19:0] disc_resend, idle_ping;
  logic [7:0]  max_tries;

  // link state mirror
  logic        link_seen, server_up, sending, held_blk;
  logic [7:0]  tries;
  logic [31:0] rx_time, tx_time, srv_addr;
  logic [15:0] cur_id, rx_id, answer, held_cmd;
  logic [63:0] held_args;

  result_t     pending_results[$];
  logic [31:0] clock_ms;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;   // no idling on either side
  int unsigned ready_hold = 0;

  function automatic void push_result(kind_e k, logic [31:0] dest, logic [15:0] id,
                                      logic [15:0] cmd, logic [63:0] a);
    result_t r;
    r.kind = k;
    r.dest_address = dest;
    r.msg_id_res = id;
    r.command_res = cmd;
    r.args_res = a;
    r.last = 1'b0;
    pending_results.push_back(r);
  endfunction

  function automatic void start_message(logic [15:0] cmd, logic [63:0] a, logic blk,
                                        logic [31:0] now);
    cur_id = (cur_id == 16'hFFFF) ? 16'd1 : cur_id + 16'd1;
    held_cmd = cmd;
    held_args = a;
    sending = 1'b1;
    held_blk = blk;
    tries = 8'd1;
    tx_time = now;
    push_result(KindSend, srv_addr, cur_id, held_cmd, held_args);
  endfunction

  function automatic void predict_link(event_t e);
    int unsigned before_cnt;
    logic [31:0] interval;
    logic [63:0] init_args;
    before_cnt = pending_results.size();
    init_args = {32'd0, srv_id, dev_ver};
    case (e.mode)
      ModeTick: begin
        if (e.link_up) begin
          if (!link_seen) begin
            link_seen = 1'b1;
            push_result(KindLinkUp, '0, '0, '0, '0);
          end
          if (sending) begin
            interval = server_up ? 32'(conn_resend) : 32'(disc_resend);
            if (e.now_ms - tx_time > interval) begin
              if (server_up && tries >= max_tries) begin
                server_up = 1'b0;
                srv_addr = Broadcast;
                push_result(KindServerDn, '0, '0, '0, '0);
              end else begin
                if (tries != 8'hFF) tries++;
                tx_time = e.now_ms;
                push_result(KindSend, srv_addr, cur_id, held_cmd, held_args);
              end
            end
          end else if (e.now_ms - rx_time >= 32'(idle_ping)) begin
            start_message(CmdPing, '0, 1'b0, e.now_ms);
          end
        end else if (link_seen) begin
          link_seen = 1'b0;
          if (server_up) begin
            server_up = 1'b0;
            push_result(KindServerDn, '0, '0, '0, '0);
          end
          push_result(KindLinkDown, '0, '0, '0, '0);
        end
      end
      ModeRx: begin
        if (!link_seen) begin
          link_seen = 1'b1;
          push_result(KindLinkUp, '0, '0, '0, '0);
        end
        if (e.pkt_length >= HeaderBytes && e.pkt_device_id == dev_id) begin
          if (!server_up) begin
            tries = '0;
            server_up = 1'b1;
            srv_addr = e.src_address;
            push_result(KindServerUp, '0, '0, '0, '0);
          end
          rx_time = e.now_ms;
          if (e.command == CmdInit || e.command == CmdInitAck) begin
            rx_id = '0;
            tries = '0;
            if (e.command == CmdInit)
              push_result(KindReply, srv_addr, e.msg_id, CmdInitAck, init_args);
            else
              sending = 1'b0;
          end else if (e.command == CmdPing) begin
            push_result(KindReply, srv_addr, e.msg_id, CmdMsgAck, '0);
          end else if (e.command == CmdMsgAck) begin
            if (sending && e.msg_id == cur_id) begin
              sending = 1'b0;
              tries = '0;
              if (held_cmd != CmdPing)
                push_result(KindDelivered, '0, cur_id, held_cmd, {48'd0, e.args[15:0]});
            end
          end else if (e.msg_id > rx_id || (rx_id - e.msg_id) > StaleWindow) begin
            rx_id = e.msg_id;
            push_result(KindCommand, '0, e.msg_id, e.command, e.args);
          end else if (e.msg_id == rx_id) begin
            push_result(KindReply, srv_addr, e.msg_id, CmdMsgAck, {48'd0, answer});
          end
        end
      end
      ModeSend: begin
        if (sending && held_blk && !e.force_send) begin
          push_result(KindRefused, '0, '0, '0, '0);
        end else begin
          if (sending && held_cmd != CmdPing)
            push_result(KindCancelled, '0, cur_id, held_cmd, '0);
          start_message(e.command, e.args, e.blocking, e.now_ms);
          push_result(KindAccepted, '0, cur_id, '0, '0);
        end
      end
      ModeResp: begin
        answer = e.args[15:0];
        push_result(KindReply, srv_addr, rx_id, CmdMsgAck, {48'd0, answer});
      end
      ModeStart: begin
        srv_addr = Broadcast;
        server_up = 1'b0;
        link_seen = 1'b0;
        sending = 1'b0;
        rx_time = '0;
        tx_time = '0;
        cur_id = '0;
        start_message(CmdInit, init_args, 1'b1, e.now_ms);
      end
      default: ;
    endcase
    if (pending_results.size() > before_cnt)
      pending_results[pending_results.size()-1].last = 1'b1;
  endfunction

  function automatic event_t random_event(logic [2:0] mode);
    event_t e;
    e.mode = mode;
    e.now_ms = clock_ms;
    e.link_up = 1'b1;
    e.src_address = $urandom;
    e.pkt_length = $urandom_range(20, 65535);
    e.pkt_device_id = dev_id;
    e.msg_id = $urandom;
    e.command = $urandom_range(0, 65531);
    e.args = {$urandom, $urandom};
    e.blocking = $urandom_range(0, 1);
    e.force_send = $urandom_range(0, 1);
    return e;
  endfunction

  task automatic send_event(event_t e);
    int unsigned r, gap;
    r = $urandom_range(0, 99);
    gap = quiet ? 0 : (r < 3) ? $urandom_range(20, 60) : (r < 55) ? 0 : $urandom_range(1, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata <= {2'b00, e.force_send, e.blocking, e.args, e.command, e.msg_id,
                     e.pkt_device_id, e.pkt_length, e.src_address, e.link_up,
                     e.now_ms, e.mode};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_link(e);
    @(negedge clk_i);
  endtask

  // wait until idle; events without results may still be in flight
  task automatic settle_link();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(idx) << 3;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegDeviceId:   dev_id = value;
      RegServerId:   srv_id = value[15:0];
      RegVersion:    dev_ver = value[15:0];
      RegConnResend: conn_resend = value[15:0];
      RegDiscResend: disc_resend = value[19:0];
      RegIdlePing:   idle_ping = value[19:0];
      RegMaxTries:   max_tries = value[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [63:0] dev, logic [15:0] sid, logic [15:0] ver,
                           logic [15:0] conn, logic [19:0] disc, logic [19:0] idle,
                           logic [7:0] mt);
    settle_link();
    write_reg(RegDeviceId, dev);
    write_reg(RegServerId, {48'd0, sid});
    write_reg(RegVersion, {48'd0, ver});
    write_reg(RegConnResend, {48'd0, conn});
    write_reg(RegDiscResend, {44'd0, disc});
    write_reg(RegIdlePing, {44'd0, idle});
    write_reg(RegMaxTries, {56'd0, mt});
  endtask

  task automatic test_directed();
    event_t e;
    configure(64'h0123_4567_89AB_CDEF, 16'hA55A, 16'h0102, 16'd100, 20'd300,
              20'd500, 8'd2);
    clock_ms = 32'd50;
    e = random_event(ModeTick); e.link_up = 1'b0; send_event(e);  // nothing seen yet
    e = random_event(ModeStart); send_event(e);
    clock_ms += 600;
    e = random_event(ModeTick); send_event(e);                     // link up, resend INIT
    e = random_event(ModeRx); e.pkt_length = 16'd19; send_event(e);
    e = random_event(ModeRx); e.pkt_device_id = ~dev_id; send_event(e);
    e = random_event(ModeRx); e.pkt_length = 16'd20; e.command = CmdInitAck; send_event(e);
    e = random_event(ModeRx); e.command = CmdInit; send_event(e);
    e = random_event(ModeRx); e.command = CmdPing; send_event(e);
    e = random_event(ModeSend); e.blocking = 1'b1; send_event(e);
    e = random_event(ModeSend); e.force_send = 1'b0; send_event(e); // refused
    e = random_event(ModeSend); e.force_send = 1'b1; e.blocking = 1'b0; send_event(e);
    e = random_event(ModeRx); e.command = CmdMsgAck; e.msg_id = cur_id; send_event(e);
    e = random_event(ModeRx); e.msg_id = 16'd5; send_event(e);
    e = random_event(ModeResp); send_event(e);
    e = random_event(ModeRx); e.msg_id = 16'd5; send_event(e);       // duplicate
    e = random_event(ModeRx); e.msg_id = 16'd3; send_event(e);       // stale
    e = random_event(ModeRx); e.msg_id = 16'd40000; send_event(e);
    e = random_event(ModeRx); e.msg_id = 16'd4; send_event(e);       // far behind: taken
    e = random_event(ModeSend); e.command = 16'hFFFF; send_event(e);
    for (int i = 0; i < 4; i++) begin                                // resends, then lost
      clock_ms += 200;
      e = random_event(ModeTick); send_event(e);
    end
    e = random_event(ModeRx); send_event(e);
    e = random_event(ModeTick); e.link_up = 1'b0; send_event(e);    // server and link down
    for (int m = 5; m < 8; m++) begin
      e = random_event(3'(m)); send_event(e);
    end
  endtask

  task automatic test_id_wrap();
    event_t e;
    quiet = 1'b1;
    for (int i = 0; i < 20; i++) begin
      e = random_event(ModeSend);
      e.force_send = 1'b1;
      e.command = (i % 7 == 0) ? CmdPing : 16'(i);
      send_event(e);
    end
    quiet = 1'b0;
  endtask

  task automatic test_random(int unsigned count, int unsigned max_step);
    event_t e;
    int unsigned r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      clock_ms += ($urandom_range(0, 49) == 0) ? $urandom : $urandom_range(0, max_step);
      if (r < 30) begin
        e = random_event(ModeTick);
        e.link_up = ($urandom_range(0, 9) != 0);
      end else if (r < 55) begin
        e = random_event(ModeRx);
        case ($urandom_range(0, 7))
          0: e.command = CmdInit;
          1: e.command = CmdInitAck;
          2: e.command = CmdPing;
          3, 4: begin
            e.command = CmdMsgAck;
            if ($urandom_range(0, 3) != 0) e.msg_id = cur_id;
          end
          default: e.msg_id = rx_id + 16'($urandom_range(0, 2));
        endcase
        if ($urandom_range(0, 3) == 0) e.src_address = srv_addr;
      end else if (r < 70) begin
        e = random_event(ModeSend);
        if ($urandom_range(0, 5) == 0) e.command = $urandom;
        e.force_send = ($urandom_range(0, 4) == 0);
      end else if (r < 80) begin
        e = random_event(ModeResp);
      end else if (r < 85) begin
        e = random_event(ModeStart);
      end else if (r < 95) begin
        e = random_event(ModeRx);
        if ($urandom_range(0, 1)) e.pkt_length = $urandom_range(0, 19);
        else e.pkt_device_id = {$urandom, $urandom};
      end else begin
        e = random_event(3'($urandom_range(5, 7)));
      end
      send_event(e);
    end
  endtask

  task automatic test_config_settings();
    configure(64'd0, 16'd0, 16'd0, 16'd1, 20'd1, 20'd1, 8'd1);
    test_random(80, 4);
    configure({$urandom, $urandom}, 16'($urandom), 16'($urandom), 16'd1000, 20'd10000,
              20'd5000, 8'd5);
    clock_ms = 32'hFFFF_F000;                                        // crosses the wrap
    test_random(80, 1500);
    configure('1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 8'hFF);
    test_random(70, 300000);
    configure({$urandom, $urandom}, 16'($urandom), 16'($urandom), 16'($urandom_range(1, 50)),
              20'($urandom_range(1, 80)), 20'($urandom_range(1, 100)), 8'd3);
    test_random(80, 60);
  endtask

  // result sink back pressure: mostly short stalls, some long, quiet stretches none
  always @(negedge clk_i) begin
    if (!rst_ni || quiet) begin
      m_axis_tready <= rst_ni;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:1]:   begin ready_hold <= $urandom_range(20, 60); m_axis_tready <= 1'b0; end
        [2:34]:  m_axis_tready <= 1'b0;
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[3:0] !== want.kind || m_axis_tdata[35:4] !== want.dest_address ||
            m_axis_tdata[51:36] !== want.msg_id_res ||
            m_axis_tdata[67:52] !== want.command_res ||
            m_axis_tdata[131:68] !== want.args_res || m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want kind=%0d dest=%h id=%h cmd=%h args=%h last=%b / got kind=%0d dest=%h id=%h cmd=%h args=%h last=%b",
                     want.kind, want.dest_address, want.msg_id_res, want.command_res,
                     want.args_res, want.last, m_axis_tdata[3:0], m_axis_tdata[35:4],
                     m_axis_tdata[51:36], m_axis_tdata[67:52], m_axis_tdata[131:68],
                     m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    dev_id = '0; srv_id = '0; dev_ver = '0;
    conn_resend = 16'd1000; disc_resend = 20'd10000; idle_ping = 20'd5000;
    max_tries = 8'd5;
    link_seen = 1'b0; server_up = 1'b0; sending = 1'b0; held_blk = 1'b0;
    tries = '0; rx_time = '0; tx_time = '0; srv_addr = Broadcast;
    cur_id = '0; rx_id = '0; answer = '0; held_cmd = '0; held_args = '0;
    clock_ms = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_config_settings();
    test_id_wrap();
    settle_link();
    repeat (20) @(posedge clk_i);
    mismatches += pending_results.size();
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
